// ===== src/tco_pkg.sv =====
// Package for the two-center orbit stepper: payload types, codes, fixed widths.
// No dependencies; the unit, the top level, the checker and the bench use it.
`default_nettype none

package tco_pkg;

   localparam int WORD_W     = 32;  // position, velocity, acceleration words
   localparam int MUL_W      = 33;  // signed multiplier operand width
   localparam int SQRT_IN_W  = 64;  // square-root radicand width
   localparam int QUO_W      = 31;  // quotient bits of one division
   localparam int SQRT_STEPS = 32;  // root bits of one square root
   localparam int CNT_W      = 6;
   localparam int CFG_W      = 31;
   localparam int DAMP_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int STEP_W     = 5;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   localparam logic [CFG_W-1:0]  MASS_ONE_RESET   = 31'd65536;
   localparam logic [CFG_W-1:0]  MASS_TWO_RESET   = 31'd65536;
   localparam logic [CFG_W-1:0]  SEPARATION_RESET = 31'd131072;
   localparam logic [CFG_W-1:0]  TIME_STEP_RESET  = 31'd655;
   localparam logic [DAMP_W-1:0] DAMPING_RESET    = 17'd65536;

   typedef enum logic [1:0] {
      OP_ADVANCE  = 2'd0,
      OP_LOAD_POS = 2'd1,
      OP_LOAD_VEL = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASS_ONE   = 3'd0,
      CSR_MASS_TWO   = 3'd1,
      CSR_SEPARATION = 3'd2,
      CSR_TIME_STEP  = 3'd3,
      CSR_DAMPING    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_MUL  = 2'd0,
      CMD_DIV  = 2'd1,
      CMD_SQRT = 2'd2
   } unit_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ISSUE = 2'd1,
      ST_WAIT  = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   typedef enum logic [STEP_W-1:0] {
      STEP_SQ_X   = 5'd0,
      STEP_SQ_Y   = 5'd1,
      STEP_SQ_DZ1 = 5'd2,
      STEP_RAD1   = 5'd3,
      STEP_Q1     = 5'd4,
      STEP_P1     = 5'd5,
      STEP_SQ_DZ2 = 5'd6,
      STEP_RAD2   = 5'd7,
      STEP_Q2     = 5'd8,
      STEP_P2     = 5'd9,
      STEP_AX1    = 5'd10,
      STEP_AX2    = 5'd11,
      STEP_AY1    = 5'd12,
      STEP_AY2    = 5'd13,
      STEP_AZ1    = 5'd14,
      STEP_AZ2    = 5'd15,
      STEP_VX1    = 5'd16,
      STEP_VX2    = 5'd17,
      STEP_VY1    = 5'd18,
      STEP_VY2    = 5'd19,
      STEP_VZ1    = 5'd20,
      STEP_VZ2    = 5'd21,
      STEP_PX     = 5'd22,
      STEP_PY     = 5'd23,
      STEP_PZ     = 5'd24
   } step_type;

   typedef struct packed {
      logic         start;
      unit_cmd_type cmd;
   } unit_ctrl_type;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [WORD_W-1:0] value_x;
      logic signed [WORD_W-1:0] value_y;
      logic signed [WORD_W-1:0] value_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] pos_z;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== src/tco_chan_if.sv =====
// Valid/ready channel carrying one payload struct.
// Payload types come from tco_pkg.
`default_nettype none

interface tco_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/tco_unit.sv =====
// Shared arithmetic unit: registered multiply with floor shift, radix-2 divide,
// bitwise integer square root. Uses tco_pkg.
`default_nettype none

module tco_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tco_pkg::unit_ctrl_type        ctrl,
   input  wire logic [tco_pkg::SQRT_IN_W-1:0] opa,
   input  wire logic [64-FRAC_BITS:0]         opb,
   output logic                               done,
   output logic signed [65-FRAC_BITS:0]       res
);

   localparam int R2_W   = 65 - FRAC_BITS;
   localparam int PROD_W = 2 * tco_pkg::MUL_W - FRAC_BITS;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   tco_pkg::unit_cmd_type             cmd_ff, cmd_in;
   logic [tco_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]          res_ff, res_in;
   logic [R2_W-1:0]                   rem_ff, rem_in;
   logic [R2_W-1:0]                   dvs_ff, dvs_in;
   logic [tco_pkg::QUO_W-1:0]         work_ff, work_in;
   logic [tco_pkg::SQRT_IN_W-1:0]     v_ff, v_in;
   logic [tco_pkg::SQRT_IN_W-1:0]     r_ff, r_in;
   logic [tco_pkg::SQRT_IN_W-1:0]     b_ff, b_in;

   logic signed [2*tco_pkg::MUL_W-1:0] prod;
   logic [R2_W:0]                      trial;
   logic [tco_pkg::QUO_W-1:0]          quo_next;
   logic [tco_pkg::SQRT_IN_W-1:0]      rb;
   logic [tco_pkg::SQRT_IN_W-1:0]      root_next;

   assign prod = $signed(opa[tco_pkg::MUL_W-1:0]) * $signed(opb[tco_pkg::MUL_W-1:0]);
   assign trial = {rem_ff, work_ff[tco_pkg::QUO_W-1]};
   assign rb = r_ff + b_ff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      work_in   = work_ff;
      v_in      = v_ff;
      r_in      = r_ff;
      b_in      = b_ff;
      quo_next  = work_ff;
      root_next = r_ff;
      if (ctrl.start) begin
         cmd_in = ctrl.cmd;
         cnt_in = '0;
         unique case (ctrl.cmd)
            tco_pkg::CMD_MUL: begin
               res_in  = PROD_W'(prod >>> FRAC_BITS);
               done_in = 1'b1;
               busy_in = 1'b0;
            end
            tco_pkg::CMD_DIV: begin
               // high part is below the divisor, so 31 quotient bits suffice
               rem_in  = R2_W'(opa[tco_pkg::SQRT_IN_W-1:tco_pkg::QUO_W]);
               work_in = opa[tco_pkg::QUO_W-1:0];
               dvs_in  = opb;
               busy_in = 1'b1;
            end
            tco_pkg::CMD_SQRT: begin
               v_in    = opa;
               r_in    = '0;
               b_in    = tco_pkg::SQRT_IN_W'(1) << (tco_pkg::SQRT_IN_W - 2);
               busy_in = 1'b1;
            end
            default: busy_in = 1'b0;
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff + tco_pkg::CNT_W'(1);
         case (cmd_ff)
            tco_pkg::CMD_DIV: begin
               if (trial >= {1'b0, dvs_ff}) begin
                  rem_in   = R2_W'(trial - {1'b0, dvs_ff});
                  quo_next = {work_ff[tco_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  rem_in   = trial[R2_W-1:0];
                  quo_next = {work_ff[tco_pkg::QUO_W-2:0], 1'b0};
               end
               work_in = quo_next;
               if (cnt_ff == tco_pkg::CNT_W'(tco_pkg::QUO_W - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  res_in  = PROD_W'(quo_next);
               end
            end
            tco_pkg::CMD_SQRT: begin
               if (v_ff >= rb) begin
                  v_in      = v_ff - rb;
                  root_next = (r_ff >> 1) + b_ff;
               end else begin
                  root_next = r_ff >> 1;
               end
               r_in = root_next;
               b_in = b_ff >> 2;
               if (cnt_ff == tco_pkg::CNT_W'(tco_pkg::SQRT_STEPS - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  res_in  = PROD_W'(root_next[tco_pkg::WORD_W-1:0]);
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cmd_ff  <= tco_pkg::CMD_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cmd_ff  <= cmd_in;
         cnt_ff  <= cnt_in;
      end
      res_ff  <= res_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      work_ff <= work_in;
      v_ff    <= v_in;
      r_ff    <= r_in;
      b_ff    <= b_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

`default_nettype wire

// ===== src/two_center_orbit_step_core.sv =====
// Top level of the two-center orbit stepper: sequencer, body state, registers.
// Uses tco_pkg, tco_chan_if and tco_unit.
//
// Usage:
//   req_if carries one item: op (advance, load position, load velocity) and
//   three signed fixed-point components. rsp_if returns one item per request
//   with the body position after it. Registers are written on csr_write_en
//   with csr_index and csr_write_data; write them only while the block idles.
//   An advance runs 25 micro-steps on the shared unit: 19 multiplies, 4
//   divisions and 2 square roots. A load skips them and goes straight to
//   the output register. The block takes one item at a time: the
//   sequencer owns the unit for the whole item and req_if.ready is low
//   until it finishes.
//   The result sits in an output register, so the next item is accepted while
//   a result waits; an item finishing while rsp_if is still stalled waits
//   for the output register to drain.
//   Reset (synchronous, active high) zeroes position and velocity, restores
//   register defaults and empties the output register.
`default_nettype none

module two_center_orbit_step_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tco_chan_if.sink                           req_if,
   tco_chan_if.source                         rsp_if,
   input  wire logic                          csr_write_en,
   input  wire logic [tco_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tco_pkg::CFG_W-1:0]     csr_write_data
);

   localparam int R2_W   = 65 - FRAC_BITS;
   localparam int PROD_W = 2 * tco_pkg::MUL_W - FRAC_BITS;
   localparam int ACC_W  = PROD_W + 1;
   localparam int W      = tco_pkg::WORD_W;
   localparam int MW     = tco_pkg::MUL_W;

   tco_pkg::state_type state_ff, state_in;
   tco_pkg::step_type  step_ff, step_in;

   logic [tco_pkg::CFG_W-1:0]  mass_one_ff, mass_one_in;
   logic [tco_pkg::CFG_W-1:0]  mass_two_ff, mass_two_in;
   logic [tco_pkg::CFG_W-1:0]  separation_ff, separation_in;
   logic [tco_pkg::CFG_W-1:0]  time_step_ff, time_step_in;
   logic [tco_pkg::DAMP_W-1:0] damping_ff, damping_in;

   logic signed [W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [W-1:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic signed [W-1:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;

   logic [R2_W-1:0]                 xy_ff, xy_in;
   logic [R2_W-1:0]                 r2_ff, r2_in;
   logic [W-1:0]                    radius_ff, radius_in;
   logic [tco_pkg::QUO_W-1:0]       q_ff, q_in;
   logic [tco_pkg::QUO_W-1:0]       p1_ff, p1_in, p2_ff, p2_in;
   logic signed [ACC_W-1:0]         acc_ff, acc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   tco_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                           req_fire;
   logic                           out_free;
   logic                           load_out;
   logic                           step_done;
   tco_pkg::op_type                req_op;
   tco_pkg::unit_ctrl_type         unit_ctrl;
   logic                           unit_start;
   tco_pkg::unit_cmd_type          unit_cmd;
   logic [tco_pkg::SQRT_IN_W-1:0]  unit_opa;
   logic [R2_W-1:0]                unit_opb;
   logic                           unit_done;
   logic signed [PROD_W-1:0]       unit_res;
   logic signed [ACC_W-1:0]        res_ext;

   logic [MW-1:0] x33, y33, z33, nx33, ny33, dz1, dz2, half33;
   logic [tco_pkg::SQRT_IN_W-1:0] rad_in;
   logic [R2_W-1:0] one_r2;

   function automatic logic signed [W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      logic fits;
      fits = (v[ACC_W-1:W-1] == '0) || (v[ACC_W-1:W-1] == '1);
      if (fits) begin
         return $signed(v[W-1:0]);
      end else if (v[ACC_W-1]) begin
         return tco_pkg::WORD_MIN;
      end else begin
         return tco_pkg::WORD_MAX;
      end
   endfunction

   assign req_op    = tco_pkg::op_type'(req_if.data.op);
   assign req_fire  = req_if.valid && req_if.ready;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign step_done = (state_ff == tco_pkg::ST_WAIT) && unit_done;
   assign res_ext   = ACC_W'(unit_res);
   assign one_r2    = R2_W'(1) << FRAC_BITS;
   assign unit_ctrl = '{start: unit_start, cmd: unit_cmd};

   // operands derived from the position, which holds until the final position steps
   assign x33    = {px_ff[W-1], px_ff};
   assign y33    = {py_ff[W-1], py_ff};
   assign z33    = {pz_ff[W-1], pz_ff};
   assign nx33   = MW'(0) - x33;
   assign ny33   = MW'(0) - y33;
   assign half33 = MW'(separation_ff[tco_pkg::CFG_W-1:1]);
   assign dz1    = half33 - z33;
   assign dz2    = MW'(0) - half33 - z33;
   // radicand saturates when r2 shifted up leaves 64 bits
   assign rad_in = r2_ff[R2_W-1] ? '1 : {r2_ff[R2_W-2:0], {FRAC_BITS{1'b0}}};

   // micro-step decoder
   always_comb begin
      unit_cmd = tco_pkg::CMD_MUL;
      unit_opa = '0;
      unit_opb = '0;
      unique case (step_ff)
         tco_pkg::STEP_SQ_X: begin
            unit_opa = tco_pkg::SQRT_IN_W'(x33);
            unit_opb = R2_W'(x33);
         end
         tco_pkg::STEP_SQ_Y: begin
            unit_opa = tco_pkg::SQRT_IN_W'(y33);
            unit_opb = R2_W'(y33);
         end
         tco_pkg::STEP_SQ_DZ1: begin
            unit_opa = tco_pkg::SQRT_IN_W'(dz1);
            unit_opb = R2_W'(dz1);
         end
         tco_pkg::STEP_SQ_DZ2: begin
            unit_opa = tco_pkg::SQRT_IN_W'(dz2);
            unit_opb = R2_W'(dz2);
         end
         tco_pkg::STEP_RAD1, tco_pkg::STEP_RAD2: begin
            unit_cmd = tco_pkg::CMD_SQRT;
            unit_opa = rad_in;
         end
         tco_pkg::STEP_Q1: begin
            unit_cmd = tco_pkg::CMD_DIV;
            unit_opa = tco_pkg::SQRT_IN_W'({mass_one_ff, {FRAC_BITS{1'b0}}});
            unit_opb = r2_ff;
         end
         tco_pkg::STEP_Q2: begin
            unit_cmd = tco_pkg::CMD_DIV;
            unit_opa = tco_pkg::SQRT_IN_W'({mass_two_ff, {FRAC_BITS{1'b0}}});
            unit_opb = r2_ff;
         end
         tco_pkg::STEP_P1, tco_pkg::STEP_P2: begin
            unit_cmd = tco_pkg::CMD_DIV;
            unit_opa = tco_pkg::SQRT_IN_W'({q_ff, {FRAC_BITS{1'b0}}});
            unit_opb = R2_W'(radius_ff);
         end
         tco_pkg::STEP_AX1: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(p1_ff));
            unit_opb = R2_W'(nx33);
         end
         tco_pkg::STEP_AX2: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(p2_ff));
            unit_opb = R2_W'(nx33);
         end
         tco_pkg::STEP_AY1: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(p1_ff));
            unit_opb = R2_W'(ny33);
         end
         tco_pkg::STEP_AY2: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(p2_ff));
            unit_opb = R2_W'(ny33);
         end
         tco_pkg::STEP_AZ1: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(p1_ff));
            unit_opb = R2_W'(dz1);
         end
         tco_pkg::STEP_AZ2: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(p2_ff));
            unit_opb = R2_W'(dz2);
         end
         tco_pkg::STEP_VX1: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(damping_ff));
            unit_opb = R2_W'({vx_ff[W-1], vx_ff});
         end
         tco_pkg::STEP_VY1: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(damping_ff));
            unit_opb = R2_W'({vy_ff[W-1], vy_ff});
         end
         tco_pkg::STEP_VZ1: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(damping_ff));
            unit_opb = R2_W'({vz_ff[W-1], vz_ff});
         end
         tco_pkg::STEP_VX2: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(time_step_ff));
            unit_opb = R2_W'({ax_ff[W-1], ax_ff});
         end
         tco_pkg::STEP_VY2: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(time_step_ff));
            unit_opb = R2_W'({ay_ff[W-1], ay_ff});
         end
         tco_pkg::STEP_VZ2: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(time_step_ff));
            unit_opb = R2_W'({az_ff[W-1], az_ff});
         end
         tco_pkg::STEP_PX: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(time_step_ff));
            unit_opb = R2_W'({vx_ff[W-1], vx_ff});
         end
         tco_pkg::STEP_PY: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(time_step_ff));
            unit_opb = R2_W'({vy_ff[W-1], vy_ff});
         end
         tco_pkg::STEP_PZ: begin
            unit_opa = tco_pkg::SQRT_IN_W'(MW'(time_step_ff));
            unit_opb = R2_W'({vz_ff[W-1], vz_ff});
         end
         default: unit_cmd = tco_pkg::CMD_MUL;
      endcase
   end

   tco_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_unit (
      .clock (clock),
      .reset (reset),
      .ctrl  (unit_ctrl),
      .opa   (unit_opa),
      .opb   (unit_opb),
      .done  (unit_done),
      .res   (unit_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tco_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_op == tco_pkg::OP_ADVANCE) ? tco_pkg::ST_ISSUE
                                                          : tco_pkg::ST_DONE;
            end
         end
         tco_pkg::ST_ISSUE: state_in = tco_pkg::ST_WAIT;
         tco_pkg::ST_WAIT: begin
            if (unit_done) begin
               state_in = (step_ff == tco_pkg::STEP_PZ) ? tco_pkg::ST_DONE
                                                        : tco_pkg::ST_ISSUE;
            end
         end
         tco_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tco_pkg::ST_IDLE;
            end
         end
         default: state_in = tco_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      unit_start   = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         tco_pkg::ST_IDLE:  req_if.ready = 1'b1;
         tco_pkg::ST_ISSUE: unit_start   = 1'b1;
         tco_pkg::ST_WAIT:  load_out     = 1'b0;
         tco_pkg::ST_DONE:  load_out     = out_free;
         default:           req_if.ready = 1'b0;
      endcase
   end

   // datapath and register file updates
   always_comb begin
      step_in       = step_ff;
      mass_one_in   = mass_one_ff;
      mass_two_in   = mass_two_ff;
      separation_in = separation_ff;
      time_step_in  = time_step_ff;
      damping_in    = damping_ff;
      px_in = px_ff;  py_in = py_ff;  pz_in = pz_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  vz_in = vz_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  az_in = az_ff;
      xy_in     = xy_ff;
      r2_in     = r2_ff;
      radius_in = radius_ff;
      q_in      = q_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      acc_in    = acc_ff;

      if (csr_write_en) begin
         unique case (tco_pkg::csr_index_type'(csr_index))
            tco_pkg::CSR_MASS_ONE:   mass_one_in   = csr_write_data;
            tco_pkg::CSR_MASS_TWO:   mass_two_in   = csr_write_data;
            tco_pkg::CSR_SEPARATION: separation_in = csr_write_data;
            tco_pkg::CSR_TIME_STEP:  time_step_in  = csr_write_data;
            tco_pkg::CSR_DAMPING:    damping_in    = csr_write_data[tco_pkg::DAMP_W-1:0];
            default:                 damping_in    = damping_ff;
         endcase
      end

      if (req_fire) begin
         step_in = tco_pkg::STEP_SQ_X;
         case (req_op)
            tco_pkg::OP_LOAD_POS: begin
               px_in = req_if.data.value_x;
               py_in = req_if.data.value_y;
               pz_in = req_if.data.value_z;
            end
            tco_pkg::OP_LOAD_VEL: begin
               vx_in = req_if.data.value_x;
               vy_in = req_if.data.value_y;
               vz_in = req_if.data.value_z;
            end
            default: step_in = tco_pkg::STEP_SQ_X;
         endcase
      end

      if (step_done) begin
         step_in = tco_pkg::step_type'(step_ff + tco_pkg::STEP_W'(1));
         unique case (step_ff)
            tco_pkg::STEP_SQ_X:   xy_in = unit_res[R2_W-1:0];
            tco_pkg::STEP_SQ_Y:   xy_in = xy_ff + unit_res[R2_W-1:0];
            tco_pkg::STEP_SQ_DZ1,
            tco_pkg::STEP_SQ_DZ2: r2_in = xy_ff + unit_res[R2_W-1:0] + one_r2;
            tco_pkg::STEP_RAD1,
            tco_pkg::STEP_RAD2:   radius_in = unit_res[W-1:0];
            tco_pkg::STEP_Q1,
            tco_pkg::STEP_Q2:     q_in = unit_res[tco_pkg::QUO_W-1:0];
            tco_pkg::STEP_P1:     p1_in = unit_res[tco_pkg::QUO_W-1:0];
            tco_pkg::STEP_P2:     p2_in = unit_res[tco_pkg::QUO_W-1:0];
            tco_pkg::STEP_AX1, tco_pkg::STEP_AY1, tco_pkg::STEP_AZ1,
            tco_pkg::STEP_VX1, tco_pkg::STEP_VY1, tco_pkg::STEP_VZ1:
               acc_in = res_ext;
            tco_pkg::STEP_AX2:    ax_in = sat_word(acc_ff + res_ext);
            tco_pkg::STEP_AY2:    ay_in = sat_word(acc_ff + res_ext);
            tco_pkg::STEP_AZ2:    az_in = sat_word(acc_ff + res_ext);
            tco_pkg::STEP_VX2:    vx_in = sat_word(acc_ff + res_ext);
            tco_pkg::STEP_VY2:    vy_in = sat_word(acc_ff + res_ext);
            tco_pkg::STEP_VZ2:    vz_in = sat_word(acc_ff + res_ext);
            tco_pkg::STEP_PX:     px_in = sat_word(ACC_W'(px_ff) + res_ext);
            tco_pkg::STEP_PY:     py_in = sat_word(ACC_W'(py_ff) + res_ext);
            tco_pkg::STEP_PZ:     pz_in = sat_word(ACC_W'(pz_ff) + res_ext);
            default:              acc_in = acc_ff;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in      = 1'b1;
         rsp_data_in.pos_x = px_ff;
         rsp_data_in.pos_y = py_ff;
         rsp_data_in.pos_z = pz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tco_pkg::ST_IDLE;
         step_ff       <= tco_pkg::STEP_SQ_X;
         rsp_valid_ff  <= 1'b0;
         mass_one_ff   <= tco_pkg::MASS_ONE_RESET;
         mass_two_ff   <= tco_pkg::MASS_TWO_RESET;
         separation_ff <= tco_pkg::SEPARATION_RESET;
         time_step_ff  <= tco_pkg::TIME_STEP_RESET;
         damping_ff    <= tco_pkg::DAMPING_RESET;
         px_ff <= '0;  py_ff <= '0;  pz_ff <= '0;
         vx_ff <= '0;  vy_ff <= '0;  vz_ff <= '0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         mass_one_ff   <= mass_one_in;
         mass_two_ff   <= mass_two_in;
         separation_ff <= separation_in;
         time_step_ff  <= time_step_in;
         damping_ff    <= damping_in;
         px_ff <= px_in;  py_ff <= py_in;  pz_ff <= pz_in;
         vx_ff <= vx_in;  vy_ff <= vy_in;  vz_ff <= vz_in;
      end
      ax_ff <= ax_in;  ay_ff <= ay_in;  az_ff <= az_in;
      xy_ff       <= xy_in;
      r2_ff       <= r2_in;
      radius_ff   <= radius_in;
      q_ff        <= q_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/tco_checker.sv =====
// Port-level checks for the orbit stepper, bound to its top level.
// Uses tco_pkg; sees only the top-level ports.
`default_nettype none

module tco_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire tco_pkg::req_payload_type req_data,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire tco_pkg::rsp_payload_type rsp_data
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // a stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // one item in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("item accepted while busy");

   // a load of position into an empty output answers with the loaded value
   a_load_pos: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.op == tco_pkg::OP_LOAD_POS) && !rsp_valid |->
      ##2 (rsp_valid && (rsp_data.pos_x == $past(req_data.value_x, 2))
           && (rsp_data.pos_y == $past(req_data.value_y, 2))
           && (rsp_data.pos_z == $past(req_data.value_z, 2))))
      else $error("load position result mismatch");

endmodule

bind two_center_orbit_step_core tco_checker u_tco_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_data  (req_if.data),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

`default_nettype wire

// ===== sim/two_center_orbit_step_core_test.sv =====
// Self-checking bench for two_center_orbit_step_core: drives step and load items,
// predicts the body position in fixed point and checks every returned item.
// Depends on tco_pkg, tco_chan_if and the core.
`timescale 1ns / 100ps

module two_center_orbit_step_core_test;

   localparam int FB = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [tco_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tco_pkg::CFG_W-1:0] csr_write_data = '0;

   tco_chan_if #(.payload_type(tco_pkg::req_payload_type)) req_if ();
   tco_chan_if #(.payload_type(tco_pkg::rsp_payload_type)) rsp_if ();

   two_center_orbit_step_core #(.FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [30:0] m_one, m_two, sep, h_step;
   logic [16:0] damp;
   logic signed [31:0] px, py, pz, vx, vy, vz;

   tco_pkg::req_payload_type pending_items[$];
   tco_pkg::rsp_payload_type expected_pos[$];
   int errors = 0;
   int hold_cycles = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic logic signed [63:0] shr_fl(input logic signed [63:0] v);
      return v >>> FB;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return tco_pkg::WORD_MAX;
      if (v < -64'sd2147483648) return tco_pkg::WORD_MIN;
      return v[31:0];
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] pull_of(input logic [63:0] xy,
         input logic signed [63:0] dz, input logic [30:0] mass);
      logic [63:0] m, r2, rin, rad, q;
      m = dz < 0 ? -dz : dz;
      r2 = xy + ((m * m) >> FB) + (64'd1 << FB);
      rin = (r2 > (64'hffff_ffff_ffff_ffff >> FB)) ? 64'hffff_ffff_ffff_ffff : r2 << FB;
      rad = root64(rin);
      q = ({33'd0, mass} << FB) / r2;
      return $signed((q << FB) / rad);
   endfunction

   task automatic advance_body();
      logic signed [63:0] x, y, z, half, dz1, dz2, p1, p2, ax, ay, az, h, f;
      logic [63:0] ux, uy, xy;
      x = px; y = py; z = pz;
      half = {33'd0, sep >> 1};
      dz1 = half - z;
      dz2 = -half - z;
      ux = x < 0 ? -x : x;
      uy = y < 0 ? -y : y;
      xy = ((ux * ux) >> FB) + ((uy * uy) >> FB);
      p1 = pull_of(xy, dz1, m_one);
      p2 = pull_of(xy, dz2, m_two);
      ax = clamp32(shr_fl(p1 * -x) + shr_fl(p2 * -x));
      ay = clamp32(shr_fl(p1 * -y) + shr_fl(p2 * -y));
      az = clamp32(shr_fl(p1 * dz1) + shr_fl(p2 * dz2));
      h = {33'd0, h_step};
      f = {47'd0, damp};
      vx = clamp32(shr_fl(f * vx) + shr_fl(h * ax));
      vy = clamp32(shr_fl(f * vy) + shr_fl(h * ay));
      vz = clamp32(shr_fl(f * vz) + shr_fl(h * az));
      px = clamp32(x + shr_fl(h * vx));
      py = clamp32(y + shr_fl(h * vy));
      pz = clamp32(z + shr_fl(h * vz));
   endtask

   task automatic predict(input tco_pkg::req_payload_type it);
      tco_pkg::rsp_payload_type r;
      case (it.op)
         tco_pkg::OP_ADVANCE: advance_body();
         tco_pkg::OP_LOAD_POS: begin
            px = it.value_x; py = it.value_y; pz = it.value_z;
         end
         tco_pkg::OP_LOAD_VEL: begin
            vx = it.value_x; vy = it.value_y; vz = it.value_z;
         end
         default: ;
      endcase
      r.pos_x = px; r.pos_y = py; r.pos_z = pz;
      expected_pos.push_back(r);
   endtask

   // driver
   int gap = 0;
   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
   end
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict(req_if.data);
            void'(pending_items.pop_front());
         end
         if (req_if.valid && !req_if.ready) begin
            // keep offering
         end else if (gap > 0) begin
            gap--;
            req_if.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_if.valid <= 1'b1;
            req_if.data <= pending_items[0];
            gap = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(2);
         end else req_if.valid <= 1'b0;
      end
   end

   // receiver hold-off counter
   always @(posedge clock) begin
      if (!reset && hold_cycles > 0) hold_cycles--;
   end

   // monitor
   initial rsp_if.ready = 1'b0;
   always @(posedge clock) begin
      tco_pkg::rsp_payload_type w;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pos.size() == 0) begin
               report("unexpected item", rsp_if.data.pos_x, '0);
            end else begin
               w = expected_pos.pop_front();
               if (rsp_if.data.pos_x !== w.pos_x) report("pos_x", rsp_if.data.pos_x, w.pos_x);
               if (rsp_if.data.pos_y !== w.pos_y) report("pos_y", rsp_if.data.pos_y, w.pos_y);
               if (rsp_if.data.pos_z !== w.pos_z) report("pos_z", rsp_if.data.pos_z, w.pos_z);
            end
         end
         if (hold_cycles > 0) rsp_if.ready <= 1'b0;
         else if ($urandom_range(15) == 0) rsp_if.ready <= 1'b0;
         else rsp_if.ready <= 1'b1;
      end
   end

   function automatic logic signed [31:0] rnd_word();
      case ($urandom_range(7))
         0: return tco_pkg::WORD_MAX;
         1: return tco_pkg::WORD_MIN;
         2: return $signed($urandom_range(20)) - 10;
         3, 4: return $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_item(input logic [1:0] op, input logic signed [31:0] x,
         input logic signed [31:0] y, input logic signed [31:0] z);
      tco_pkg::req_payload_type it;
      it.op = op; it.value_x = x; it.value_y = y; it.value_z = z;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_if.valid || expected_pos.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // the caller drops the write enable after its last write
   task automatic write_reg(input tco_pkg::csr_index_type idx,
         input logic [tco_pkg::CFG_W-1:0] v);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      case (idx)
         tco_pkg::CSR_MASS_ONE: m_one = v;
         tco_pkg::CSR_MASS_TWO: m_two = v;
         tco_pkg::CSR_SEPARATION: sep = v;
         tco_pkg::CSR_TIME_STEP: h_step = v;
         tco_pkg::CSR_DAMPING: damp = v[16:0];
         default: ;
      endcase
   endtask

   task automatic random_setting(input int k);
      case (k)
         0: begin
            write_reg(tco_pkg::CSR_MASS_ONE, 31'h7fff_ffff);
            write_reg(tco_pkg::CSR_MASS_TWO, '0);
            write_reg(tco_pkg::CSR_SEPARATION, 31'h7fff_ffff);
            write_reg(tco_pkg::CSR_TIME_STEP, 31'h7fff_ffff);
            write_reg(tco_pkg::CSR_DAMPING, 31'h0001_ffff);
         end
         1: begin
            write_reg(tco_pkg::CSR_MASS_ONE, '0);
            write_reg(tco_pkg::CSR_MASS_TWO, 31'h7fff_ffff);
            write_reg(tco_pkg::CSR_SEPARATION, '0);
            write_reg(tco_pkg::CSR_TIME_STEP, '0);
            write_reg(tco_pkg::CSR_DAMPING, '0);
         end
         default: begin
            write_reg(tco_pkg::CSR_MASS_ONE, tco_pkg::CFG_W'($urandom_range(32'h0004_0000)));
            write_reg(tco_pkg::CSR_MASS_TWO, tco_pkg::CFG_W'($urandom_range(32'h0004_0000)));
            write_reg(tco_pkg::CSR_SEPARATION,
                      tco_pkg::CFG_W'($urandom_range(32'h0008_0000)));
            write_reg(tco_pkg::CSR_TIME_STEP, tco_pkg::CFG_W'($urandom_range(32'h0000_4000)));
            write_reg(tco_pkg::CSR_DAMPING, tco_pkg::CFG_W'($urandom_range(65536)));
         end
      endcase
      csr_write_en <= 1'b0;
   endtask

   initial begin
      m_one = tco_pkg::MASS_ONE_RESET; m_two = tco_pkg::MASS_TWO_RESET;
      sep = tco_pkg::SEPARATION_RESET;
      h_step = tco_pkg::TIME_STEP_RESET; damp = tco_pkg::DAMPING_RESET;
      px = 0; py = 0; pz = 0; vx = 0; vy = 0; vz = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: defaults, extremes, unused selector, velocity load
      queue_item(tco_pkg::OP_ADVANCE, 0, 0, 0);
      queue_item(tco_pkg::OP_LOAD_POS, 32'sh0001_0000, 0, 32'sh0000_8000);
      queue_item(tco_pkg::OP_LOAD_VEL, 0, 32'sh0000_4000, 0);
      repeat (3) queue_item(tco_pkg::OP_ADVANCE, 0, 0, 0);
      queue_item(2'd3, tco_pkg::WORD_MAX, tco_pkg::WORD_MIN, -1);
      queue_item(tco_pkg::OP_LOAD_POS, tco_pkg::WORD_MAX, tco_pkg::WORD_MIN, tco_pkg::WORD_MAX);
      queue_item(tco_pkg::OP_ADVANCE, 0, 0, 0);
      queue_item(tco_pkg::OP_LOAD_VEL, tco_pkg::WORD_MIN, tco_pkg::WORD_MAX, tco_pkg::WORD_MIN);
      queue_item(tco_pkg::OP_ADVANCE, 0, 0, 0);
      queue_item(tco_pkg::OP_LOAD_POS, tco_pkg::WORD_MIN, -1, 0);
      queue_item(tco_pkg::OP_ADVANCE, 0, 0, 0);
      // long receiver stall while items keep coming
      hold_cycles = 3000;
      drain();
      for (int k = 0; k < 2; k++) begin
         random_setting(k);
         queue_item(tco_pkg::OP_LOAD_POS, rnd_word(), rnd_word(), rnd_word());
         queue_item(tco_pkg::OP_LOAD_VEL, rnd_word(), rnd_word(), rnd_word());
         repeat (4) queue_item(tco_pkg::OP_ADVANCE, 0, 0, 0);
         queue_item(2'd3, rnd_word(), rnd_word(), rnd_word());
         drain();
      end
      for (int ph = 0; ph < 9; ph++) begin
         random_setting(ph == 8 ? 0 : 2);
         for (int i = 0; i < 100; i++) begin
            case ($urandom_range(19))
               0, 1: queue_item(tco_pkg::OP_LOAD_POS, rnd_word(), rnd_word(), rnd_word());
               2, 3: queue_item(tco_pkg::OP_LOAD_VEL, rnd_word(), rnd_word(), rnd_word());
               4: queue_item(2'd3, $urandom, $urandom, $urandom);
               default: queue_item(tco_pkg::OP_ADVANCE, $urandom, $urandom, $urandom);
            endcase
         end
         drain();
      end
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #(3_000_000 * 12);
      $display("tb: failure");
      $finish;
   end
endmodule
